### hw/rtl/cdfs_pkg.sv
// shared constants and codes of the tabulated cdf sampler
package cdfs_pkg;

	// uniform fraction width (value times 65536)
	localparam int U_W = 16;

	// result field widths
	localparam int OUT_VAL_W = 16;
	localparam int BIN_W     = 8;

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

endpackage

### hw/rtl/cdfs_if.sv
// valid/ready channel interfaces for request and result items

interface cdfs_req_if #(
	parameter int POINT_WIDTH  = 16,
	parameter int WEIGHT_WIDTH = 16
);
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic                               first_entry;
	logic signed [POINT_WIDTH-1:0]      point_value;
	logic        [WEIGHT_WIDTH-1:0]     weight;
	logic        [cdfs_pkg::U_W-1:0]    u_select;
	logic        [cdfs_pkg::U_W-1:0]    u_within;

	modport source (
		output valid, cmd, first_entry, point_value, weight, u_select, u_within,
		input  ready
	);
	modport sink (
		input  valid, cmd, first_entry, point_value, weight, u_select, u_within,
		output ready
	);
endinterface

interface cdfs_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cdfs_pkg::OUT_VAL_W-1:0] sample_value;
	logic        [cdfs_pkg::BIN_W-1:0]     bin_index;
	logic                                 status;

	modport source (
		output valid, sample_value, bin_index, status,
		input  ready
	);
	modport sink (
		input  valid, sample_value, bin_index, status,
		output ready
	);
endinterface

### hw/rtl/cdfs_table.sv
// point and cumulative weight memories, one write port and one shared read address
module cdfs_table #(
	parameter int DEPTH = 256,
	parameter int PW    = 16,
	parameter int CW    = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [PW-1:0]            wpoint,
	input  logic [CW-1:0]            wcum,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [PW-1:0]            pt_rdata_q,
	output logic [CW-1:0]            cum_rdata_q
);

	logic [PW-1:0] pt_mem  [DEPTH];
	logic [CW-1:0] cum_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			pt_mem[waddr]  <= wpoint;
			cum_mem[waddr] <= wcum;
		end
	end

	always_ff @(posedge clk) begin
		pt_rdata_q  <= pt_mem[raddr];
		cum_rdata_q <= cum_mem[raddr];
	end

endmodule

### hw/rtl/cdfs_mul.sv
// shared signed multiplier with registered product
module cdfs_mul #(
	parameter int A_W = 25,
	parameter int B_W = 17
) (
	input  logic                     clk,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### hw/rtl/tabulated_cdf_sampler.sv
// top level of the tabulated cdf sampler: sequencer, search and interpolation control
//
// req carries load and sample items, rsp carries one result item per sample item.
// a load item (cmd load) appends a point and its weight to the table and keeps a
// running cumulative weight; first_entry restarts the table at entry zero, and
// loads beyond DEPTH entries are dropped. a load gives no result.
// a sample item forms u_select times the total weight on the shared multiplier, then
// binary-searches the cumulative memory for the first entry above that threshold,
// one memory read and compare per cycle, and interpolates between the found point
// and the one before it by u_within on the same multiplier.
// the search goes over the single read port of the table. req.ready is low from a sample
// accept until the result enters the output register.
// an empty table or a zero total gives status empty with value and index zero.
// the result sits in an output register; while rsp stalls it holds, and a further
// finished sample waits in its last state until the register is free.
// reset clears the entry count, the total and the output valid; the memories are not
// cleared, and only entries below the entry count are used in a result.
module tabulated_cdf_sampler #(
	parameter int DEPTH        = 256,
	parameter int POINT_WIDTH  = 16,
	parameter int WEIGHT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	cdfs_req_if.sink       req,
	cdfs_rsp_if.source     rsp
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = WEIGHT_WIDTH + IW;
	localparam int UW    = cdfs_pkg::U_W;
	localparam int PW    = POINT_WIDTH;
	localparam int MA_W  = (CW > PW) ? CW + 1 : PW + 1;
	localparam int MB_W  = UW + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int OVW   = cdfs_pkg::OUT_VAL_W;
	localparam int BW    = cdfs_pkg::BIN_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_THR,
		S_THR2,
		S_SRCH,
		S_PHI,
		S_PLO,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

	state_t state_q;

	// table bookkeeping
	logic [CNT_W-1:0]   count_q;
	logic [CW-1:0]      total_q;

	// per sample working registers
	logic [UW-1:0]      us_q;
	logic [UW-1:0]      uw_q;
	logic [IW-1:0]      lo_q;
	logic [IW-1:0]      hi_q;
	logic [IW-1:0]      mid_q;
	logic [IW-1:0]      idx_q;
	logic [CW+UW-1:0]   thr_q;
	logic [PW-1:0]      hi_pt_q;
	logic [PW-1:0]      lo_pt_q;
	logic signed [PW:0] diff_q;

	// finished result, then output register
	logic [OVW-1:0]     res_val_q;
	logic [BW-1:0]      res_bin_q;
	logic               res_status_q;
	logic               out_valid_q;
	logic [OVW-1:0]     out_val_q;
	logic [BW-1:0]      out_bin_q;
	logic               out_status_q;

	logic               accept;
	logic [CNT_W-1:0]   ld_idx;
	logic [CW-1:0]      ld_prev;
	logic [CW-1:0]      ld_cum;
	logic               ld_ok;
	logic               we;
	logic               empty;

	logic [IW-1:0]      raddr;
	logic [PW-1:0]      pt_rdata;
	logic [CW-1:0]      cum_rdata;

	logic               above;
	logic [IW-1:0]      nlo;
	logic [IW-1:0]      nhi;
	logic [IW:0]        nsum;
	logic [IW-1:0]      nmid;
	logic               srch_done;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  p_q;
	logic [PW-1:0]          interp;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// load path: restart or append, dropped once the table is full
	assign ld_idx  = req.first_entry ? '0 : count_q;
	assign ld_prev = req.first_entry ? '0 : total_q;
	assign ld_cum  = ld_prev + CW'(req.weight);
	assign ld_ok   = (ld_idx != CNT_W'(DEPTH));
	assign we      = accept && (req.cmd == cdfs_pkg::CMD_LOAD) && ld_ok;
	assign empty   = (count_q == '0) || (total_q == '0);

	// one search step: entry mid is above the threshold when C*65536 > u*total
	assign above     = ({cum_rdata, {UW{1'b0}}} > thr_q);
	assign nlo       = above ? lo_q : mid_q + 1'b1;
	assign nhi       = above ? mid_q : hi_q;
	assign nsum      = {1'b0, nlo} + {1'b0, nhi};
	assign nmid      = nsum[IW:1];
	assign srch_done = (nlo == nhi);

	// floor((hi - lo) * u_within / 65536) is the product without its low bits
	assign interp = lo_pt_q + p_q[UW +: PW];

	// shared multiplier: threshold first, interpolation later
	always_comb begin
		if (state_q == S_THR) begin
			mul_a = $signed(MA_W'(total_q));
			mul_b = $signed({1'b0, us_q});
		end else begin
			mul_a = MA_W'(diff_q);
			mul_b = $signed({1'b0, uw_q});
		end
	end

	// table read address; the read data is registered and arrives in the cycle after
	always_comb begin
		unique case (state_q)
			S_THR2:  raddr = (hi_q == '0) ? '0 : (hi_q >> 1);
			S_SRCH:  raddr = srch_done ? nlo : nmid;
			S_PHI:   raddr = idx_q - 1'b1;
			default: raddr = '0;
		endcase
	end

	cdfs_table #(
		.DEPTH (DEPTH),
		.PW    (PW),
		.CW    (CW)
	) u_table (
		.clk         (clk),
		.we          (we),
		.waddr       (ld_idx[IW-1:0]),
		.wpoint      (req.point_value),
		.wcum        (ld_cum),
		.raddr       (raddr),
		.pt_rdata_q  (pt_rdata),
		.cum_rdata_q (cum_rdata)
	);

	cdfs_mul #(
		.A_W (MA_W),
		.B_W (MB_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in done the register is refilled below instead
			if (rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == cdfs_pkg::CMD_LOAD) begin
							if (ld_ok) begin
								count_q <= ld_idx + 1'b1;
								total_q <= ld_cum;
							end
						end else if (empty) begin
							res_val_q    <= '0;
							res_bin_q    <= '0;
							res_status_q <= cdfs_pkg::STATUS_EMPTY;
							state_q      <= S_DONE;
						end else begin
							us_q    <= req.u_select;
							uw_q    <= req.u_within;
							lo_q    <= '0;
							hi_q    <= IW'(count_q - 1'b1);
							state_q <= S_THR;
						end
					end
				end
				S_THR: begin
					state_q <= S_THR2;
				end
				S_THR2: begin
					thr_q <= p_q[CW+UW-1:0];
					if (hi_q == '0) begin
						// single entry, nothing to search
						idx_q   <= '0;
						state_q <= S_PHI;
					end else begin
						mid_q   <= hi_q >> 1;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (srch_done) begin
						idx_q   <= nlo;
						state_q <= S_PHI;
					end else begin
						lo_q  <= nlo;
						hi_q  <= nhi;
						mid_q <= nmid;
					end
				end
				S_PHI: begin
					hi_pt_q <= pt_rdata;
					if (idx_q == '0) begin
						// first entry returns its point as it stands
						res_val_q    <= OVW'(pt_rdata);
						res_bin_q    <= BW'(idx_q);
						res_status_q <= cdfs_pkg::STATUS_OK;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_PLO;
					end
				end
				S_PLO: begin
					lo_pt_q <= pt_rdata;
					diff_q  <= $signed({hi_pt_q[PW-1], hi_pt_q})
						- $signed({pt_rdata[PW-1], pt_rdata});
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					res_val_q    <= OVW'(interp);
					res_bin_q    <= BW'(idx_q);
					res_status_q <= cdfs_pkg::STATUS_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// wait for a free output register
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_val_q    <= res_val_q;
						out_bin_q    <= res_bin_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.sample_value = out_val_q;
	assign rsp.bin_index    = out_bin_q;
	assign rsp.status       = out_status_q;

endmodule

### hw/rtl/cdfs_checker.sv
// port level checks of the tabulated cdf sampler, bound to the top level
module cdfs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  logic                            req_cmd,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  logic [cdfs_pkg::OUT_VAL_W-1:0]  rsp_sample_value,
	input  logic [cdfs_pkg::BIN_W-1:0]      rsp_bin_index,
	input  logic                            rsp_status
);

	// a result item stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	// a stalled result item keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			$stable(rsp_sample_value) && $stable(rsp_bin_index) && $stable(rsp_status))
		else $error("result payload changed while stalled");

	// a sample item keeps the block busy for at least the next cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == cdfs_pkg::CMD_SAMPLE) |=> !req_ready)
		else $error("request accepted while a sample is in work");

	// an empty table result carries zero value and index
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == cdfs_pkg::STATUS_EMPTY) |->
			(rsp_sample_value == '0) && (rsp_bin_index == '0))
		else $error("empty table result with nonzero fields");

endmodule

bind tabulated_cdf_sampler cdfs_checker u_cdfs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_cmd          (req.cmd),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_sample_value (rsp.sample_value),
	.rsp_bin_index    (rsp.bin_index),
	.rsp_status       (rsp.status)
);
